// ----- rtl/pidd_pkg.sv -----
// Package for the PID controller core (derivative on measurement).
// Holds field widths, reset values, op and register codes, the sequencer
// state type and the output clamp. No dependencies.
`timescale 1ns / 1ps

package pidd_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int GAIN_W    = 24;
  localparam int TIME_W    = 32;
  localparam int GAIN_PAD  = TIME_W - GAIN_W;
  localparam int WIDE_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 2;

  // Product magnitude limit, 2^61
  localparam logic [WIDE_W-1:0] SAT_LIM = 64'h2000_0000_0000_0000;
  localparam int SAT_BITS = 62;

  localparam logic [GAIN_W-1:0]        GAIN_PROP_RST  = 24'd65536;
  localparam logic [GAIN_W-1:0]        GAIN_INTEG_RST = 24'd0;
  localparam logic [GAIN_W-1:0]        GAIN_DERIV_RST = 24'd0;
  localparam logic signed [WIDE_W-1:0] OUT_MIN_RST    = -64'sd6553600;
  localparam logic signed [WIDE_W-1:0] OUT_MAX_RST    = 64'sd6553600;
  localparam logic [TIME_W-1:0]        SAMPLE_RST     = 32'd100;

  typedef enum logic [OP_W-1:0] {
    OP_COMPUTE = 2'd0,
    OP_MANUAL  = 2'd1,
    OP_AUTO    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_PROP  = 3'd0,
    REG_GAIN_INTEG = 3'd1,
    REG_GAIN_DERIV = 3'd2,
    REG_OUT_MIN    = 3'd3,
    REG_OUT_MAX    = 3'd4,
    REG_SAMPLE     = 3'd5
  } cfg_idx_e;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL_P  = 9'b000000010,
    S_MUL_I1 = 9'b000000100,
    S_MUL_I2 = 9'b000001000,
    S_MUL_D  = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_FIN_I  = 9'b001000000,
    S_FIN_O  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  // Raise to lo first, then lower to hi (crossed limits give hi)
  function automatic logic signed [WIDE_W-1:0] clamp_lim(
    input logic signed [WIDE_W-1:0] x,
    input logic signed [WIDE_W-1:0] lo,
    input logic signed [WIDE_W-1:0] hi
  );
    logic signed [WIDE_W-1:0] y;
    y = (x < lo) ? lo : x;
    y = (y > hi) ? hi : y;
    return y;
  endfunction

endpackage

// ----- rtl/pid_controller_deriv_on_measurement_core.sv -----
// PID controller core with derivative on measurement and anti-windup.
// Shared 64-bit adder under a one-hot sequencer; depends on pidd_pkg.
`timescale 1ns / 1ps

// Usage
//   Slave stream carries one request per item: tuser holds the op (compute,
//   set manual, set automatic, reset memory), tdata the measurement,
//   setpoint, time stamp and manual output. Master stream returns one result
//   per request: tdata holds the drive value, tuser the updated flag.
//   Configuration is a plain write port (enable, index, data); write it only
//   while the core is idle. Indexes beyond the register list are ignored.
// Compute sequence
//   A compute that forms a new output runs four bit-serial multiplies on the
//   shared adder (24, 24, 32 and 24 steps, each followed by an unload step)
//   and a restoring divide of 62 - FRAC_BITS steps, one bit per cycle. The
//   adder is the pacing unit; the core takes one request at a time.
// Reset and stall
//   Reset restores register defaults, automatic mode and cleared memory.
//   The result waits in an output register; the core takes the next request
//   while it waits, but holds a new result until the receiver takes the old.
module pid_controller_deriv_on_measurement_core
  import pidd_pkg::*;
#(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int IN_FLD_W   = 3 * VALUE_WIDTH + TIME_W,
  localparam int IN_DW      = ((IN_FLD_W + 7) / 8) * 8,
  localparam int OUT_DW     = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int CFG_DW     = (VALUE_WIDTH > TIME_W) ? VALUE_WIDTH : TIME_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // measured, setpoint, time_now, manual_output (lowest bit up), zero pad
  input  logic [IN_DW-1:0]     s_axis_tdata_i,
  // op
  input  logic [OP_W-1:0]      s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // drive, zero pad
  output logic [OUT_DW-1:0]    m_axis_tdata_o,
  // updated
  output logic [0:0]           m_axis_tuser_o
);

  localparam int VW      = VALUE_WIDTH;
  localparam int EW      = VW + 1;
  localparam int NW      = SAT_BITS - FRAC_BITS;
  localparam int CNT_MAX = (NW > TIME_W) ? NW : TIME_W;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  // ---------------------------------------------------------------- fields
  logic [VW-1:0]     in_meas, in_setp, in_man;
  logic [TIME_W-1:0] in_now;
  logic [OP_W-1:0]   in_op;

  assign in_meas = s_axis_tdata_i[VW-1:0];
  assign in_setp = s_axis_tdata_i[2*VW-1:VW];
  assign in_now  = s_axis_tdata_i[2*VW+TIME_W-1:2*VW];
  assign in_man  = s_axis_tdata_i[3*VW+TIME_W-1:2*VW+TIME_W];
  assign in_op   = s_axis_tuser_i;

  // --------------------------------------------------------------- registers
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic [GAIN_W-1:0]   gain_prop_q, gain_prop_d;
  logic [GAIN_W-1:0]   gain_integ_q, gain_integ_d;
  logic [GAIN_W-1:0]   gain_deriv_q, gain_deriv_d;
  logic [VW-1:0]       out_min_q, out_min_d;
  logic [VW-1:0]       out_max_q, out_max_d;
  logic [TIME_W-1:0]   sample_q, sample_d;

  logic                auto_q, auto_d;
  logic                has_q, has_d;
  logic [VW-1:0]       integ_q, integ_d;
  logic [VW-1:0]       prev_out_q, prev_out_d;
  logic [VW-1:0]       prev_meas_q, prev_meas_d;
  logic [TIME_W-1:0]   prev_time_q, prev_time_d;

  logic                m_valid_q, m_valid_d;
  logic [VW-1:0]       drive_q, drive_d;
  logic                upd_out_q, upd_out_d;
  logic                upd_q, upd_d;

  // datapath
  logic [WIDE_W-1:0]        acc_q, acc_d;
  logic                     sat_q, sat_d;
  logic [WIDE_W-1:0]        mag_q, mag_d;
  logic                     neg_q, neg_d;
  logic [TIME_W-1:0]        gm_q, gm_d;
  logic [TIME_W-1:0]        rem_q, rem_d;
  logic [NW-1:0]            divn_q, divn_d;
  logic signed [WIDE_W-1:0] pterm_q, pterm_d;
  logic signed [WIDE_W-1:0] iterm_q, iterm_d;
  logic signed [WIDE_W-1:0] dterm_q, dterm_d;
  logic [EW-1:0]            err_q, err_d;
  logic [EW-1:0]            dmeas_q, dmeas_d;
  logic [VW-1:0]            meas_q, meas_d;
  logic [TIME_W-1:0]        now_q, now_d;
  logic [TIME_W-1:0]        dt_q, dt_d;

  // ------------------------------------------------------------ combinational
  logic [EW-1:0]            err_w, err_abs_w, err_q_abs, dmeas_w, dmeas_q_abs;
  logic [TIME_W-1:0]        dt_w, st_w;
  logic signed [WIDE_W-1:0] lo_w, hi_w, integ_ext, prev_out_ext, man_ext;
  logic signed [WIDE_W-1:0] clamp_integ_w, clamp_out_w, clamp_man_w;
  logic signed [WIDE_W-1:0] integ_sum_w, out_sum_w;
  logic [WIDE_W-1:0]        mul_r;
  logic signed [WIDE_W-1:0] mul_p;
  logic [WIDE_W-1:0]        alu_a, alu_b, alu_sum;
  logic                     alu_cin;
  logic [TIME_W:0]          rem_sh;
  logic                     div_ge;
  logic                     is_mul;

  assign err_w   = {in_setp[VW-1], in_setp} - {in_meas[VW-1], in_meas};
  assign dmeas_w = {in_meas[VW-1], in_meas} - {prev_meas_q[VW-1], prev_meas_q};
  assign err_abs_w   = err_w[VW]   ? EW'(-err_w)   : err_w;
  assign err_q_abs   = err_q[VW]   ? EW'(-err_q)   : err_q;
  assign dmeas_q_abs = dmeas_q[VW] ? EW'(-dmeas_q) : dmeas_q;

  assign dt_w = in_now - prev_time_q;
  assign st_w = (sample_q == '0) ? TIME_W'(1) : sample_q;

  assign lo_w         = {{(WIDE_W-VW){out_min_q[VW-1]}}, out_min_q};
  assign hi_w         = {{(WIDE_W-VW){out_max_q[VW-1]}}, out_max_q};
  assign integ_ext    = {{(WIDE_W-VW){integ_q[VW-1]}}, integ_q};
  assign prev_out_ext = {{(WIDE_W-VW){prev_out_q[VW-1]}}, prev_out_q};
  assign man_ext      = {{(WIDE_W-VW){in_man[VW-1]}}, in_man};

  assign clamp_integ_w = clamp_lim(integ_ext, lo_w, hi_w);
  assign clamp_out_w   = clamp_lim(prev_out_ext, lo_w, hi_w);
  assign clamp_man_w   = clamp_lim(man_ext, lo_w, hi_w);
  assign integ_sum_w   = clamp_lim(integ_ext + iterm_q, lo_w, hi_w);
  assign out_sum_w     = clamp_lim(pterm_q + integ_ext - dterm_q, lo_w, hi_w);

  // Saturated product of the finished multiply, sign applied
  assign mul_r = sat_q ? SAT_LIM : acc_q;
  assign mul_p = neg_q ? -$signed(mul_r) : $signed(mul_r);

  assign is_mul = state_q inside {S_MUL_P, S_MUL_I1, S_MUL_I2, S_MUL_D};
  assign rem_sh = {rem_q, divn_q[NW-1]};

  // Shared adder: shift-add step of the multiply, trial subtract of the divide
  always_comb begin
    if (state_q == S_DIV) begin
      alu_a   = {{(WIDE_W-TIME_W-1){1'b0}}, rem_sh};
      alu_b   = ~{{(WIDE_W-TIME_W){1'b0}}, dt_q};
      alu_cin = 1'b1;
    end else begin
      alu_a   = {acc_q[WIDE_W-2:0], 1'b0};
      alu_b   = gm_q[TIME_W-1] ? mag_q : '0;
      alu_cin = 1'b0;
    end
    alu_sum = alu_a + alu_b + {{(WIDE_W-1){1'b0}}, alu_cin};
  end

  assign div_ge = ~alu_sum[WIDE_W-1];

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    gain_prop_d  = gain_prop_q;
    gain_integ_d = gain_integ_q;
    gain_deriv_d = gain_deriv_q;
    out_min_d    = out_min_q;
    out_max_d    = out_max_q;
    sample_d     = sample_q;
    auto_d       = auto_q;
    has_d        = has_q;
    integ_d      = integ_q;
    prev_out_d   = prev_out_q;
    prev_meas_d  = prev_meas_q;
    prev_time_d  = prev_time_q;
    m_valid_d    = m_valid_q;
    drive_d      = drive_q;
    upd_out_d    = upd_out_q;
    upd_d        = upd_q;
    acc_d        = acc_q;
    sat_d        = sat_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    gm_d         = gm_q;
    rem_d        = rem_q;
    divn_d       = divn_q;
    pterm_d      = pterm_q;
    iterm_d      = iterm_q;
    dterm_d      = dterm_q;
    err_d        = err_q;
    dmeas_d      = dmeas_q;
    meas_d       = meas_q;
    now_d        = now_q;
    dt_d         = dt_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_PROP:  gain_prop_d  = cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_INTEG: gain_integ_d = cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_DERIV: gain_deriv_d = cfg_wdata_i[GAIN_W-1:0];
        REG_OUT_MIN:    out_min_d    = cfg_wdata_i[VW-1:0];
        REG_OUT_MAX:    out_max_d    = cfg_wdata_i[VW-1:0];
        REG_SAMPLE:     sample_d     = cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end

    // Drop the result once the receiver takes it
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    // One shift-add step per cycle; freeze the sum once it saturates
    if (is_mul && cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      gm_d  = {gm_q[TIME_W-2:0], 1'b0};
      if (!sat_q) begin
        acc_d = alu_sum;
        if (alu_sum > SAT_LIM) begin
          sat_d = 1'b1;
        end
      end
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          upd_d   = 1'b0;
          state_d = S_DONE;
          case (in_op)
            OP_COMPUTE: begin
              if (auto_q) begin
                if (!has_q) begin
                  // first compute: capture the baseline and clamp the stored terms, no new output
                  prev_meas_d = in_meas;
                  prev_time_d = in_now;
                  integ_d     = clamp_integ_w[VW-1:0];
                  prev_out_d  = clamp_out_w[VW-1:0];
                  has_d       = 1'b1;
                end else if (dt_w >= st_w) begin
                  err_d   = err_w;
                  dmeas_d = dmeas_w;
                  meas_d  = in_meas;
                  now_d   = in_now;
                  dt_d    = dt_w;
                  mag_d   = {{(WIDE_W-EW){1'b0}}, err_abs_w};
                  neg_d   = err_w[VW];
                  gm_d    = {gain_prop_q, {GAIN_PAD{1'b0}}};
                  cnt_d   = CNT_W'(GAIN_W);
                  acc_d   = '0;
                  sat_d   = 1'b0;
                  state_d = S_MUL_P;
                end
              end
            end
            OP_MANUAL: auto_d = 1'b0;
            OP_AUTO: begin
              // bumpless switch: start from the current output
              if (!auto_q) begin
                prev_meas_d = in_meas;
                prev_out_d  = in_man;
                integ_d     = clamp_man_w[VW-1:0];
                has_d       = 1'b0;
              end
              auto_d = 1'b1;
            end
            OP_CLEAR: begin
              has_d      = 1'b0;
              integ_d    = '0;
              prev_out_d = '0;
            end
            default: ;
          endcase
        end
      end

      S_MUL_P: begin
        if (cnt_q == '0) begin
          pterm_d = mul_p >>> FRAC_BITS;
          mag_d   = {{(WIDE_W-EW){1'b0}}, err_q_abs};
          neg_d   = err_q[VW];
          gm_d    = {gain_integ_q, {GAIN_PAD{1'b0}}};
          cnt_d   = CNT_W'(GAIN_W);
          acc_d   = '0;
          sat_d   = 1'b0;
          state_d = S_MUL_I1;
        end
      end

      S_MUL_I1: begin
        if (cnt_q == '0) begin
          // keep the sign, scale the saturated product by the elapsed ticks
          mag_d   = mul_r;
          gm_d    = dt_q;
          cnt_d   = CNT_W'(TIME_W);
          acc_d   = '0;
          sat_d   = 1'b0;
          state_d = S_MUL_I2;
        end
      end

      S_MUL_I2: begin
        if (cnt_q == '0) begin
          iterm_d = mul_p >>> FRAC_BITS;
          mag_d   = {{(WIDE_W-EW){1'b0}}, dmeas_q_abs};
          neg_d   = dmeas_q[VW];
          gm_d    = {gain_deriv_q, {GAIN_PAD{1'b0}}};
          cnt_d   = CNT_W'(GAIN_W);
          acc_d   = '0;
          sat_d   = 1'b0;
          state_d = S_MUL_D;
        end
      end

      S_MUL_D: begin
        if (cnt_q == '0) begin
          // floor(floor(m / 2^F) / dt) equals floor(m / (dt * 2^F))
          divn_d  = mul_r[SAT_BITS-1:FRAC_BITS];
          rem_d   = '0;
          cnt_d   = CNT_W'(NW);
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        if (cnt_q != '0) begin
          cnt_d  = cnt_q - 1'b1;
          rem_d  = div_ge ? alu_sum[TIME_W-1:0] : rem_sh[TIME_W-1:0];
          divn_d = {divn_q[NW-2:0], div_ge};
        end else begin
          // truncate toward zero: negate the magnitude quotient
          dterm_d = neg_q ? -$signed({{(WIDE_W-NW){1'b0}}, divn_q})
                          :  $signed({{(WIDE_W-NW){1'b0}}, divn_q});
          state_d = S_FIN_I;
        end
      end

      S_FIN_I: begin
        integ_d = integ_sum_w[VW-1:0];
        state_d = S_FIN_O;
      end

      S_FIN_O: begin
        prev_out_d  = out_sum_w[VW-1:0];
        prev_meas_d = meas_q;
        prev_time_d = now_q;
        upd_d       = 1'b1;
        state_d     = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          drive_d   = prev_out_q;
          upd_out_d = upd_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      gain_prop_q  <= GAIN_PROP_RST;
      gain_integ_q <= GAIN_INTEG_RST;
      gain_deriv_q <= GAIN_DERIV_RST;
      out_min_q    <= OUT_MIN_RST[VW-1:0];
      out_max_q    <= OUT_MAX_RST[VW-1:0];
      sample_q     <= SAMPLE_RST;
      auto_q       <= 1'b1;
      has_q        <= 1'b0;
      integ_q      <= '0;
      prev_out_q   <= '0;
      prev_meas_q  <= '0;
      prev_time_q  <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      gain_prop_q  <= gain_prop_d;
      gain_integ_q <= gain_integ_d;
      gain_deriv_q <= gain_deriv_d;
      out_min_q    <= out_min_d;
      out_max_q    <= out_max_d;
      sample_q     <= sample_d;
      auto_q       <= auto_d;
      has_q        <= has_d;
      integ_q      <= integ_d;
      prev_out_q   <= prev_out_d;
      prev_meas_q  <= prev_meas_d;
      prev_time_q  <= prev_time_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drive_q   <= drive_d;
    upd_out_q <= upd_out_d;
    upd_q     <= upd_d;
    acc_q     <= acc_d;
    sat_q     <= sat_d;
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    gm_q      <= gm_d;
    rem_q     <= rem_d;
    divn_q    <= divn_d;
    pterm_q   <= pterm_d;
    iterm_q   <= iterm_d;
    dterm_q   <= dterm_d;
    err_q     <= err_d;
    dmeas_q   <= dmeas_d;
    meas_q    <= meas_d;
    now_q     <= now_d;
    dt_q      <= dt_d;
  end

  // ------------------------------------------------------------------ ports
  assign s_axis_tready_o   = (state_q == S_IDLE);
  assign m_axis_tvalid_o   = m_valid_q;
  assign m_axis_tdata_o    = OUT_DW'(drive_q);
  assign m_axis_tuser_o[0] = upd_out_q;

  // -------------------------------------------------------------- assertions
  ap_upd_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && upd_q) |-> (auto_q && has_q))
    else $error("updated result without automatic mode and baseline");

  ap_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_mul && !sat_q) |-> (acc_q <= SAT_LIM))
    else $error("unsaturated accumulator above limit");

  ap_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < dt_q))
    else $error("divider remainder not below divisor");

  ap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  ap_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

endmodule
